@@ hw/rtl/register_alarm_monitor_assert.svh @@
`ifndef REGISTER_ALARM_MONITOR_ASSERT_SVH
`define REGISTER_ALARM_MONITOR_ASSERT_SVH

// Assertion helpers for the alarm monitor: clocked, and held off while in reset.

`ifndef ASSERT_OFF

`define RALM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alarm monitor check failed");

`define RALM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("alarm monitor forbidden condition seen");

`else

`define RALM_ASSERT(lbl, clk, rst_n, prop)

`define RALM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/ralm_pkg.sv @@
`timescale 1ns / 1ps

package ralm_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CNT_W   = 6;

  localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    COND_BITMASK = 2'd0,
    COND_RANGE   = 2'd1,
    COND_CHANGE  = 2'd2,
    COND_UNKNOWN = 2'd3
  } cond_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_TRIGGER = 1'b0,
    KIND_CLEAR   = 1'b1
  } kind_e;

  // One alarm table entry
  typedef struct packed {
    cond_e             cond;
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
  } ralm_entry_t;

  // Per-entry run-time state
  typedef struct packed {
    logic              active;
    logic [VAL_W-1:0]  prev;
  } ralm_state_t;

  // Outcome of evaluating one sample
  typedef struct packed {
    logic              emit;
    kind_e             kind;
    logic              st_we;
    ralm_state_t       st_new;
  } ralm_eval_t;

  localparam ralm_entry_t ENTRY_RST = '{cond: COND_UNKNOWN, lo: '0, hi: '0};
  localparam ralm_state_t STATE_RST = '{active: 1'b0, prev: '0};

endpackage

@@ hw/rtl/ralm_eval.sv @@
`timescale 1ns / 1ps

module ralm_eval (
  input  logic                       en_i,
  input  ralm_pkg::ralm_entry_t      entry_i,
  input  ralm_pkg::ralm_state_t      state_i,
  input  logic [ralm_pkg::VAL_W-1:0] value_i,
  output ralm_pkg::ralm_eval_t       res_o
);
  import ralm_pkg::*;

  logic hit_mask;
  logic hit_range;
  logic hit;
  logic sticky;

  // Compare the value against mask and limits
  assign hit_mask  = (value_i & entry_i.hi) == entry_i.hi;
  assign hit_range = (value_i < entry_i.lo) || (value_i > entry_i.hi);

  always_comb begin
    hit    = 1'b0;
    sticky = 1'b0;
    res_o  = '{emit: 1'b0, kind: KIND_TRIGGER, st_we: 1'b0, st_new: state_i};
    case (entry_i.cond)
      COND_BITMASK: begin
        sticky = 1'b1;
        hit    = hit_mask;
      end
      COND_RANGE: begin
        sticky = 1'b1;
        hit    = hit_range;
      end
      COND_CHANGE: begin
        // record every enabled sample value, trigger on a difference
        res_o.st_we       = en_i;
        res_o.st_new.prev = value_i;
        res_o.emit        = en_i && (value_i != state_i.prev);
      end
      default: begin
        sticky = 1'b0;
      end
    endcase

    // Sticky conditions: flag edge gives one trigger or one clear
    if (sticky && en_i && (hit != state_i.active)) begin
      res_o.emit          = 1'b1;
      res_o.st_we         = 1'b1;
      res_o.st_new.active = hit;
      res_o.kind          = hit ? KIND_TRIGGER : KIND_CLEAR;
    end
  end

endmodule

@@ hw/rtl/register_alarm_monitor.sv @@
`timescale 1ns / 1ps

// Register alarm monitor. Write words (op 0) load a table entry; sample words
// (op 1) evaluate one entry and give at most one event word. The table and the
// per-entry state sit in two single-port-write memories with a registered read:
// a word is read on acceptance, evaluated in stage 1 and written back when it
// leaves stage 1, and its event word is loaded into the output register as it
// leaves. A new word is accepted every cycle while stage 1 is not held;
// back-to-back words on the same entry are served by forwarding the write-back.
// The only stall comes from the output register: a word that would
// emit waits while an earlier event has not been taken. Per-entry valid bits
// give the reset contents at once, so there is no clearing pass after reset.
// entries_in_use is written through the cfg port, which is always ready.
module register_alarm_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ralm_pkg::CNT_W-1:0] cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [ralm_pkg::IDX_W-1:0] entry_index_i,
  input  logic [1:0]                 condition_i,
  input  logic [ralm_pkg::VAL_W-1:0] low_limit_i,
  input  logic [ralm_pkg::VAL_W-1:0] high_limit_i,
  input  logic [ralm_pkg::VAL_W-1:0] sample_value_i,
  input  logic                       read_ok_i,
  // event words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ralm_pkg::IDX_W-1:0] alarm_index_o,
  output logic [ralm_pkg::VAL_W-1:0] alarm_value_o,
  output logic                       event_kind_o
);
  import ralm_pkg::*;

  `include "register_alarm_monitor_assert.svh"

  // Configuration register
  logic [CNT_W-1:0] eiu_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q <= CNT_RST;
    end else if (cfg_valid_i) begin
      eiu_q <= cfg_data_i;
    end
  end

  // Memories and valid bits
  ralm_entry_t tbl_mem [ENTRIES];
  ralm_state_t st_mem  [ENTRIES];
  logic [ENTRIES-1:0] tbl_vld_q;
  logic [ENTRIES-1:0] st_vld_q;

  ralm_entry_t tbl_rdata_q;
  ralm_state_t st_rdata_q;
  logic        tbl_vld_rd_q;
  logic        st_vld_rd_q;

  // Stage 1 word
  logic             s1_vld_q;
  op_e              s1_op_q;
  logic [IDX_W-1:0] s1_idx_q;
  ralm_entry_t      s1_wr_q;
  logic [VAL_W-1:0] s1_val_q;
  logic             s1_ok_q;

  // Forwarding of the previous write-back
  logic        fw_tbl_hit_q;
  logic        fw_st_hit_q;
  ralm_entry_t fw_tbl_q;
  ralm_state_t fw_st_q;

  // Output register
  logic             out_vld_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [VAL_W-1:0] out_val_q;
  kind_e            out_kind_q;

  ralm_entry_t ent;
  ralm_state_t st;
  ralm_eval_t  ev;
  logic        in_fire;
  logic        s1_go;
  logic        s1_fire;
  logic        s1_in_table;
  logic        sample_en;
  logic        tbl_we;
  logic        st_we;
  logic        out_load;

  // Pick the current entry and state: forwarded, stored or reset contents
  always_comb begin
    if (fw_tbl_hit_q) begin
      ent = fw_tbl_q;
    end else if (tbl_vld_rd_q) begin
      ent = tbl_rdata_q;
    end else begin
      ent = ENTRY_RST;
    end
    if (fw_st_hit_q) begin
      st = fw_st_q;
    end else if (st_vld_rd_q) begin
      st = st_rdata_q;
    end else begin
      st = STATE_RST;
    end
  end

  assign s1_in_table = 32'(s1_idx_q) < ENTRIES;
  assign sample_en   = s1_vld_q && (s1_op_q == OP_SAMPLE) && s1_ok_q && s1_in_table
                       && ({1'b0, s1_idx_q} < eiu_q);

  ralm_eval u_eval (
    .en_i    (sample_en),
    .entry_i (ent),
    .state_i (st),
    .value_i (s1_val_q),
    .res_o   (ev)
  );

  // Handshake: stage 1 holds only while its event cannot be placed
  assign s1_go      = !ev.emit || !out_vld_q || out_ready_i;
  assign s1_fire    = s1_vld_q && s1_go;
  assign in_ready_o = !s1_vld_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tbl_we     = s1_fire && (s1_op_q == OP_WRITE) && s1_in_table;
  assign st_we      = s1_fire && ev.st_we;
  assign out_load   = s1_fire && ev.emit;

  // Memory read on acceptance, write-back from stage 1
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tbl_rdata_q <= tbl_mem[entry_index_i];
      st_rdata_q  <= st_mem[entry_index_i];
    end
    if (tbl_we) begin
      tbl_mem[s1_idx_q] <= s1_wr_q;
    end
    if (st_we) begin
      st_mem[s1_idx_q] <= ev.st_new;
    end
  end

  // Valid bits and their registered read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q    <= '0;
      st_vld_q     <= '0;
      tbl_vld_rd_q <= 1'b0;
      st_vld_rd_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        tbl_vld_rd_q <= tbl_vld_q[entry_index_i];
        st_vld_rd_q  <= st_vld_q[entry_index_i];
      end
      if (tbl_we) begin
        tbl_vld_q[s1_idx_q] <= 1'b1;
      end
      if (st_we) begin
        st_vld_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  // Capture a write-back that the read of the next word missed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_tbl_hit_q <= 1'b0;
      fw_st_hit_q  <= 1'b0;
    end else if (in_ready_o) begin
      fw_tbl_hit_q <= in_fire && tbl_we && (s1_idx_q == entry_index_i);
      fw_st_hit_q  <= in_fire && st_we && (s1_idx_q == entry_index_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fw_tbl_q <= s1_wr_q;
      fw_st_q  <= ev.st_new;
    end
  end

  // Advance the stage 1 word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= op_e'(op_i);
      s1_idx_q <= entry_index_i;
      s1_wr_q  <= '{cond: cond_e'(condition_i), lo: low_limit_i, hi: high_limit_i};
      s1_val_q <= sample_value_i;
      s1_ok_q  <= read_ok_i;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= s1_idx_q;
      out_val_q  <= s1_val_q;
      out_kind_q <= ev.kind;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign alarm_index_o = out_idx_q;
  assign alarm_value_o = out_val_q;
  assign event_kind_o  = out_kind_q;

  // Checks
  `RALM_ASSERT(a_write_no_event, clk_i, rst_ni,
      (s1_vld_q && (s1_op_q == OP_WRITE)) |-> !out_load)
  `RALM_ASSERT(a_fwd_needs_word, clk_i, rst_ni,
      (fw_tbl_hit_q || fw_st_hit_q) |-> s1_vld_q)
  `RALM_ASSERT(a_load_into_free, clk_i, rst_ni,
      out_load |-> (!out_vld_q || out_ready_i))
  `RALM_ASSERT_NEVER(a_stall_blocks_in, clk_i, rst_ni,
      s1_vld_q && !s1_go && in_ready_o)

endmodule
